// ===== design/ate_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ate_pkg: shared definitions for the alarm table
// Field codes, register indexes, reset values, conversion and divider sizes
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ate_pkg;

    localparam int NUM_ALARMS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int FIRE_W         = 4;      // holds 0..MAX_RESULTS
    localparam int ID_W           = 8;
    localparam int VAL_W          = 32;
    localparam int RATE_W         = 20;
    localparam int CFG_IDX_W      = 2;

    // input item modes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_SET_REL = 2'd1;
    localparam logic [1:0] MODE_SET_ABS = 2'd2;
    localparam logic [1:0] MODE_CANCEL  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_ID     = 2'd1;
    localparam logic [1:0] ST_CYCLE_LOW  = 2'd2;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd3;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CYCLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd2;

    localparam logic [VAL_W-1:0]  MODULUS_RST   = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0]  MIN_CYCLE_RST = 32'd1;
    localparam logic [RATE_W-1:0] TICK_RATE_RST = 20'd1000;

    // ms to ticks: (ms * rate + 999) / 1000, saturated to 32 bits.
    // With ms = 1000*mh + ml this is mh*rate + (ml*rate + 999) / 1000; both
    // divisions by 1000 are a multiply by RCP_1000 and a shift by RCP_SH,
    // exact for any dividend below 2^32.
    localparam int MH_W      = 23;            // ms / 1000
    localparam int ML_W      = 10;            // ms % 1000
    localparam int Y_W       = 30;            // ml * rate + 999
    localparam int RCP_W     = 29;
    localparam int RCP_SH    = 38;
    localparam int CQ_W      = MH_W + RATE_W; // full quotient
    localparam int CVT_STEPS = 4;             // register stages of the conversion
    localparam logic [RCP_W-1:0] RCP_1000 = 29'd274877907;
    localparam logic [Y_W-1:0]   ROUND_UP = 30'd999;
    localparam logic [VAL_W-1:0] MS_PER_S = 32'd1000;
    localparam logic [VAL_W-1:0] SAT_VAL  = 32'hFFFF_FFFF;

    // shift-subtract divider for the modulus reductions
    localparam int DIV_SW = VAL_W + 1;
    localparam int DIV_CW = 6;

    typedef struct packed {
        logic       in_ready;
        logic       mul;
        logic       sel;          // 0 start / expiry, 1 cycle / period
        logic       div_start;
        logic       tick_store;
        logic       sum_set;
        logic       wr_exp;
        logic       wr_per;
        logic       arm_set;
        logic       arm_clr_id;
        logic       arm_clr_idx;
        logic       rd;
        logic       scan_cap;
        logic       scan_init;
        logic       idx_inc;
        logic       pend_load;
        logic       emit;
        logic       emit_kind;
        logic [1:0] emit_status;
        logic       emit_last;
        logic       emit_pend;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] mode;
        logic       id_bad;
        logic       armed_id;
        logic       cyc_low;
        logic       match;
        logic       keep;
        logic       cvt_done;
        logic       div_done;
        logic       idx_last;
        logic       fire_full;
        logic       pend_valid;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/ate_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ate_if: request and result channels of the alarm table
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ate_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  alarm_id;
    logic [31:0] start_ms;
    logic [31:0] cycle_ms;
    logic [31:0] counter_now;

    modport source (output valid, output mode, output alarm_id, output start_ms,
                    output cycle_ms, output counter_now, input ready);
    modport sink   (input valid, input mode, input alarm_id, input start_ms,
                    input cycle_ms, input counter_now, output ready);
endinterface

interface ate_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] status;
    logic [7:0] fired_alarm;
    logic       last;

    modport source (output valid, output kind, output status, output fired_alarm,
                    output last, input ready);
    modport sink   (input valid, input kind, input status, input fired_alarm,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== design/ate_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ate_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ate_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [WIDTH-1:0]    i_wdata,
    input  wire logic                i_re,
    input  wire logic [AW-1:0]       i_raddr,
    output      logic [WIDTH-1:0]    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== design/ate_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ate_div: shift-subtract divider
// One quotient bit a cycle, 33 steps; gives the remainder.
// ----------------------------------------------------------------------------
module ate_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ate_pkg::DIV_SW-1:0]  i_dividend,
    input  wire logic [ate_pkg::VAL_W-1:0]   i_divisor,
    output      logic                        o_done,
    output      logic [ate_pkg::VAL_W-1:0]   o_rem
);
    localparam int SW = ate_pkg::DIV_SW;
    localparam int VW = ate_pkg::VAL_W;
    localparam int CW = ate_pkg::DIV_CW;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_q, n_q;
    logic [VW-1:0] r_r, n_r;
    logic [VW-1:0] r_d, n_d;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {r_r, r_q[SW-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_d    = i_divisor;
            n_r    = '0;
            n_q    = i_dividend;
            n_cnt  = CW'(SW);
        end else if (r_busy) begin
            n_q   = {r_q[SW-2:0], ge};
            n_r   = ge ? diff[VW-1:0] : trial[VW-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ===== design/ate_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ate_dp: alarm table datapath
// Request capture, config registers, tick conversion, alarm stores, scan
// counters and the result register.
// ----------------------------------------------------------------------------
module ate_dp #(
    parameter int NUM_ALARMS = ate_pkg::NUM_ALARMS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ate_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ate_pkg::VAL_W-1:0]       i_cfg_data,
    ate_in_if.sink                               i_in,
    ate_out_if.source                            o_out,
    input  wire ate_pkg::t_cmd                   i_cmd,
    output      ate_pkg::t_sts                   o_sts
);
    localparam int IW  = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int VW  = ate_pkg::VAL_W;
    localparam int FW  = ate_pkg::FIRE_W;
    localparam int RW  = ate_pkg::RATE_W;
    localparam int KW  = ate_pkg::RCP_W;
    localparam int KS  = ate_pkg::RCP_SH;
    localparam int HW  = ate_pkg::MH_W;
    localparam int LW  = ate_pkg::ML_W;
    localparam int YW  = ate_pkg::Y_W;
    localparam int QW  = ate_pkg::CQ_W;
    localparam int CS  = ate_pkg::CVT_STEPS;

    // config
    logic [VW-1:0] r_mod, r_min;
    logic [RW-1:0] r_rate;

    // captured request
    logic [1:0]    r_mode;
    logic [7:0]    r_id;
    logic [VW-1:0] r_start, r_cycle, r_now;

    // ms to ticks conversion pipeline
    logic [VW-1:0] r_cms;
    logic [HW-1:0] r_mh;
    logic [QW-1:0] r_hi;
    logic [LW-1:0] r_ml;
    logic [YW-1:0] r_y;
    logic [RW-1:0] r_q2;
    logic [CS-1:0] r_cvt;

    // working values
    logic [VW-1:0] r_inc, r_ct;
    logic [VW:0]   r_sum;
    logic          r_keep;

    // table and scan
    logic [NUM_ALARMS-1:0] r_armed;
    logic [IW-1:0]         r_idx;
    logic [FW-1:0]         r_fire;
    logic [IW-1:0]         r_pend;
    logic                  r_pend_valid;

    // result register
    logic       r_out_valid;
    logic       r_kind, r_last;
    logic [1:0] r_status;
    logic [7:0] r_fired;

    logic             accept;
    logic [IW-1:0]    id_addr, addr;
    logic [VW-1:0]    ms_sel, ticks, red_val, rd_exp, rd_per;
    logic [VW+KW-1:0] mh_prod;
    logic [VW-1:0]    mh_k, ml_full;
    logic [YW+KW-1:0] q2_prod;
    logic [QW-1:0]    cvt_quo;
    logic             div_done;
    logic [VW-1:0]    div_rem;
    logic             out_free;

    assign accept  = i_in.valid && i_cmd.in_ready;
    assign id_addr = r_id[IW-1:0];
    assign addr    = (r_mode == ate_pkg::MODE_TICK) ? r_idx : id_addr;
    assign ms_sel  = i_cmd.sel ? r_cycle : r_start;

    // ms / 1000 by reciprocal; remainder a stage later, second quotient after r_y
    assign mh_prod = {{KW{1'b0}}, ms_sel} * {{VW{1'b0}}, ate_pkg::RCP_1000};
    assign mh_k    = {{(VW-HW){1'b0}}, r_mh} * ate_pkg::MS_PER_S;
    assign ml_full = r_cms - mh_k;
    assign q2_prod = {{KW{1'b0}}, r_y} * {{YW{1'b0}}, ate_pkg::RCP_1000};
    assign cvt_quo = r_hi + {{HW{1'b0}}, r_q2};

    always_comb begin
        if (r_cms == '0) begin
            ticks = '0;
        end else if (cvt_quo == '0) begin
            ticks = VW'(1);
        end else if (cvt_quo[QW-1:VW] != '0) begin
            ticks = ate_pkg::SAT_VAL;
        end else begin
            ticks = cvt_quo[VW-1:0];
        end
    end

    // a zero modulus keeps the low 32 bits
    assign red_val = (r_mod == '0) ? r_sum[VW-1:0] : div_rem;

    ate_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_mod),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    ate_ram #(.WIDTH(VW), .DEPTH(NUM_ALARMS)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_exp),
        .i_waddr (addr),
        .i_wdata (red_val),
        .i_re    (i_cmd.rd),
        .i_raddr (addr),
        .o_rdata (rd_exp)
    );

    ate_ram #(.WIDTH(VW), .DEPTH(NUM_ALARMS)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_per),
        .i_waddr (addr),
        .i_wdata (red_val),
        .i_re    (i_cmd.rd),
        .i_raddr (addr),
        .o_rdata (rd_per)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod        <= ate_pkg::MODULUS_RST;
            r_min        <= ate_pkg::MIN_CYCLE_RST;
            r_rate       <= ate_pkg::TICK_RATE_RST;
            r_armed      <= '0;
            r_idx        <= '0;
            r_fire       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cvt        <= '0;
        end else begin
            r_cvt <= {r_cvt[CS-2:0], i_cmd.mul};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ate_pkg::CFG_MODULUS:   r_mod  <= i_cfg_data;
                    ate_pkg::CFG_MIN_CYCLE: r_min  <= i_cfg_data;
                    ate_pkg::CFG_TICK_RATE: r_rate <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.arm_set) begin
                r_armed[id_addr] <= 1'b1;
            end
            if (i_cmd.arm_clr_id) begin
                r_armed[id_addr] <= 1'b0;
            end
            if (i_cmd.arm_clr_idx) begin
                r_armed[r_idx] <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_idx        <= '0;
                r_fire       <= '0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (i_cmd.pend_load) begin
                    r_fire       <= r_fire + FW'(1);
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_in.mode;
            r_id    <= i_in.alarm_id;
            r_start <= i_in.start_ms;
            r_cycle <= i_in.cycle_ms;
            r_now   <= i_in.counter_now;
        end
        if (i_cmd.mul) begin
            r_cms <= ms_sel;
            r_mh  <= mh_prod[KS+HW-1:KS];
        end
        // free-running stages, settled once r_cvt signals cvt_done
        r_hi <= {{RW{1'b0}}, r_mh} * {{HW{1'b0}}, r_rate};
        r_ml <= ml_full[LW-1:0];
        r_y  <= {{(YW-LW){1'b0}}, r_ml} * {{(YW-RW){1'b0}}, r_rate} + ate_pkg::ROUND_UP;
        r_q2 <= q2_prod[KS+RW-1:KS];
        if (i_cmd.tick_store) begin
            if (i_cmd.sel) begin
                r_ct <= ticks;
            end else begin
                r_inc <= ticks;
            end
        end
        if (i_cmd.sum_set) begin
            if (i_cmd.sel) begin
                r_sum <= {1'b0, r_ct};
            end else if (r_mode == ate_pkg::MODE_SET_REL) begin
                r_sum <= {1'b0, r_now} + {1'b0, r_inc};
            end else begin
                r_sum <= {1'b0, r_inc};
            end
        end
        if (i_cmd.scan_cap) begin
            r_sum  <= {1'b0, rd_exp} + {1'b0, rd_per};
            r_keep <= (rd_per != '0) && (rd_per >= r_min);
        end
        if (i_cmd.pend_load) begin
            r_pend <= r_idx;
        end
        if (i_cmd.emit) begin
            r_kind   <= i_cmd.emit_kind;
            r_status <= i_cmd.emit_status;
            r_last   <= i_cmd.emit_last;
            r_fired  <= i_cmd.emit_pend ? {{(ate_pkg::ID_W-IW){1'b0}}, r_pend} : '0;
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready        = i_cmd.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.status      = r_status;
    assign o_out.fired_alarm = r_fired;
    assign o_out.last        = r_last;

    always_comb begin
        o_sts.in_valid   = i_in.valid;
        o_sts.mode       = r_mode;
        o_sts.id_bad     = {1'b0, r_id} >= 9'(NUM_ALARMS);
        o_sts.armed_id   = r_armed[id_addr];
        o_sts.cyc_low    = (r_ct != '0) && (r_ct < r_min);
        o_sts.match      = r_armed[r_idx] && (rd_exp == r_now);
        o_sts.keep       = r_keep;
        o_sts.cvt_done   = r_cvt[CS-1];
        o_sts.div_done   = div_done;
        o_sts.idx_last   = r_idx == IW'(NUM_ALARMS - 1);
        o_sts.fire_full  = r_fire == FW'(ate_pkg::MAX_RESULTS);
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
    end
endmodule
`default_nettype wire

// ===== design/ate_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ate_ctrl: alarm table controller
// Sequences set, cancel and tick requests over the datapath.
// ----------------------------------------------------------------------------
module ate_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ate_pkg::t_sts   i_sts,
    output      ate_pkg::t_cmd   o_cmd
);
    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_DECODE  = 15'h0002,
        S_MUL     = 15'h0004,
        S_CVTWAIT = 15'h0008,
        S_CHKCYC  = 15'h0010,
        S_REDGO   = 15'h0020,
        S_REDWAIT = 15'h0040,
        S_STATUS  = 15'h0080,
        S_SCANRD  = 15'h0100,
        S_SCANCHK = 15'h0200,
        S_FIRE    = 15'h0400,
        S_RLDGO   = 15'h0800,
        S_RLDWAIT = 15'h1000,
        S_NEXT    = 15'h2000,
        S_FLUSH   = 15'h4000
    } t_state;

    t_state     r_state, n_state;
    logic       r_phase, n_phase;
    logic [1:0] r_code, n_code;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_code  = r_code;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.mode == ate_pkg::MODE_TICK) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCANRD;
                end else if (i_sts.id_bad) begin
                    n_code  = ate_pkg::ST_BAD_ID;
                    n_state = S_STATUS;
                end else if (i_sts.mode == ate_pkg::MODE_CANCEL) begin
                    if (i_sts.armed_id) begin
                        o_cmd.arm_clr_id = 1'b1;
                        n_code           = ate_pkg::ST_OK;
                    end else begin
                        n_code = ate_pkg::ST_NOT_ACTIVE;
                    end
                    n_state = S_STATUS;
                end else begin
                    n_phase = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.sel = r_phase;
                n_state   = S_CVTWAIT;
            end
            S_CVTWAIT: begin
                o_cmd.sel = r_phase;
                if (i_sts.cvt_done) begin
                    o_cmd.tick_store = 1'b1;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_CHKCYC;
                    end
                end
            end
            S_CHKCYC: begin
                if (i_sts.cyc_low) begin
                    n_code  = ate_pkg::ST_CYCLE_LOW;
                    n_state = S_STATUS;
                end else begin
                    o_cmd.sum_set = 1'b1;
                    n_phase       = 1'b0;
                    n_state       = S_REDGO;
                end
            end
            S_REDGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_REDWAIT;
            end
            S_REDWAIT: begin
                if (i_sts.div_done) begin
                    if (!r_phase) begin
                        o_cmd.wr_exp  = 1'b1;
                        o_cmd.sum_set = 1'b1;
                        o_cmd.sel     = 1'b1;
                        n_phase       = 1'b1;
                        n_state       = S_REDGO;
                    end else begin
                        o_cmd.wr_per  = 1'b1;
                        o_cmd.arm_set = 1'b1;
                        n_code        = ate_pkg::ST_OK;
                        n_state       = S_STATUS;
                    end
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_kind   = ate_pkg::KIND_STATUS;
                    o_cmd.emit_status = r_code;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCANRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SCANCHK;
            end
            S_SCANCHK: begin
                o_cmd.scan_cap = 1'b1;
                n_state        = i_sts.match ? S_FIRE : S_NEXT;
            end
            S_FIRE: begin
                // the held expiry goes out once the next one is known
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    if (i_sts.pend_valid) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_kind   = ate_pkg::KIND_FIRED;
                        o_cmd.emit_status = ate_pkg::ST_OK;
                        o_cmd.emit_pend   = 1'b1;
                    end
                    o_cmd.pend_load = 1'b1;
                    if (i_sts.keep) begin
                        n_state = S_RLDGO;
                    end else begin
                        o_cmd.arm_clr_idx = 1'b1;
                        n_state           = S_NEXT;
                    end
                end
            end
            S_RLDGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_RLDWAIT;
            end
            S_RLDWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.wr_exp = 1'b1;
                    n_state      = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.fire_full || i_sts.idx_last) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCANRD;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_kind   = ate_pkg::KIND_FIRED;
                    o_cmd.emit_status = ate_pkg::ST_OK;
                    o_cmd.emit_pend   = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_code  <= ate_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_code  <= n_code;
        end
    end
endmodule
`default_nettype wire

// ===== design/alarm_table_expiry.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_table_expiry: alarm table against a shared counter
// Set, cancel and tick requests on a table of alarms; a tick request reports
// armed alarms whose expiry equals the carried counter value, up to MAX_RESULTS.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  i_in      in   valid / ready   mode, alarm_id, start_ms, cycle_ms, counter_now
//  o_out     out  valid / ready   kind, status, fired_alarm, last
//  i_cfg_*   in   write enable    i_cfg_idx, i_cfg_data (no read-back)
//
// One request is worked on at a time; i_in.ready is high only in the idle state.
// Cancel and bad alarm id go from decode straight to a status result. Set: two
// ms to tick conversions (reciprocal multiplies for the divide by 1000) and two
// 33-step modulus reductions on the shared one-bit-a-cycle divider.
// Tick: a scan through the expiry and period RAMs, one alarm after another,
// plus an expiry reload on the divider for each periodic alarm that fires.
// Reset (synchronous, i_rst_n low) disarms all alarms and loads register
// defaults; the expiry and period RAMs are not cleared.
// The result register lets a request in while a result waits; a stalled o_out
// only holds the block when a further result is due.
//
module alarm_table_expiry #(
    parameter int NUM_ALARMS = ate_pkg::NUM_ALARMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ate_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ate_pkg::VAL_W-1:0]     i_cfg_data,
    ate_in_if.sink                             i_in,
    ate_out_if.source                          o_out
);
    // controller and datapath meet only here
    ate_pkg::t_cmd cmd;
    ate_pkg::t_sts sts;

    ate_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ate_dp #(.NUM_ALARMS(NUM_ALARMS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );
endmodule
`default_nettype wire
